// ===== src/pmd_pkg.sv =====
`default_nettype none

package pmd_pkg;

  // Fixed field widths of the item channels
  localparam int ROW_FIELD_W   = 8;
  localparam int FEAT_FIELD_W  = 6;
  localparam int VALUE_FIELD_W = 16;
  localparam int DIST_W        = 22;
  localparam int CFG_W         = 7;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Register indexes
  localparam logic REG_DISTANCE_MODE = 1'b0;
  localparam logic REG_FEATURE_COUNT = 1'b1;

  // Distance modes
  localparam logic MODE_MISMATCH = 1'b0;
  localparam logic MODE_ABSOLUTE = 1'b1;

  localparam logic [CFG_W-1:0] FEATURE_COUNT_RESET = 7'd64;

  typedef struct packed {
    logic                     operation;
    logic [ROW_FIELD_W-1:0]   row_a;
    logic [ROW_FIELD_W-1:0]   row_b;
    logic [FEAT_FIELD_W-1:0]  feature_index;
    logic [VALUE_FIELD_W-1:0] feature_value;
    logic                     value_missing;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0]      distance;
    logic [ROW_FIELD_W-1:0] first_row;
    logic [ROW_FIELD_W-1:0] second_row;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_FINISH
  } state_t;

endpackage

`default_nettype wire

// ===== src/pairwise_masked_distance.sv =====
// Load item: written into the feature store at its acceptance edge, one item per cycle while idle.
// Query item: N = min(feature_count, MAX_FEATURES) features compared, N = 0 when rows are out of
//   range or feature_count is 0; one feature of each row read per cycle, through the store read,
//   term and accumulator registers; the next item is accepted from the cycle the result appears.
// Reset (rst, synchronous): control state cleared, distance_mode = 0, feature_count = 64.
//   The feature store is not cleared; its entries are undefined until loaded.
`default_nettype none

module pairwise_masked_distance #(
  parameter int MAX_ROWS     = 256,
  parameter int MAX_FEATURES = 64,
  parameter int VALUE_BITS   = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration write port
  input  wire logic                             cfg_we,
  input  wire logic                             cfg_index,
  input  wire logic [pmd_pkg::CFG_W-1:0]        cfg_data,
  // input items
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire pmd_pkg::in_item_t                in_data,
  // result items
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output pmd_pkg::out_item_t                    out_data
);

  localparam int DEPTH   = MAX_ROWS * MAX_FEATURES;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int FEAT_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CNT_W   = $clog2(MAX_FEATURES + 1);
  localparam int FC_W    = (CNT_W > pmd_pkg::CFG_W) ? CNT_W : pmd_pkg::CFG_W;
  localparam int ENTRY_W = VALUE_BITS + 1;
  localparam int SUM_W   = ((VALUE_BITS > pmd_pkg::DIST_W) ? VALUE_BITS : pmd_pkg::DIST_W) + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic                      distance_mode;
  logic [pmd_pkg::CFG_W-1:0] feature_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_mode <= pmd_pkg::MODE_MISMATCH;
      feature_count <= pmd_pkg::FEATURE_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pmd_pkg::REG_DISTANCE_MODE: distance_mode <= cfg_data[0];
        pmd_pkg::REG_FEATURE_COUNT: feature_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Compare count, saturated at the number of feature slots
  logic [FC_W-1:0]  fc_ext;
  logic [CNT_W-1:0] fc_limit;

  assign fc_ext   = FC_W'(feature_count);
  assign fc_limit = (fc_ext > FC_W'(MAX_FEATURES)) ? CNT_W'(MAX_FEATURES) : CNT_W'(fc_ext);

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  pmd_pkg::state_t state, state_next;

  logic                            accept;
  logic                            accept_load;
  logic                            accept_query;
  logic                            rows_ok;
  logic                            feat_ok;

  // query context, latched at acceptance
  logic [pmd_pkg::ROW_FIELD_W-1:0] q_row_a;
  logic [pmd_pkg::ROW_FIELD_W-1:0] q_row_b;
  logic [CNT_W-1:0]                q_limit;
  logic                            q_mode;

  logic [CNT_W-1:0]                rd_cnt;
  logic                            issue;
  logic                            rd_pending;   // read data arrives this cycle
  logic                            term_valid;   // term register holds a feature
  logic                            pipe_empty;
  logic                            out_free;
  logic                            out_load;

  assign in_ready     = (state == pmd_pkg::S_IDLE);
  assign accept       = in_valid && in_ready;
  assign accept_load  = accept && (in_data.operation == pmd_pkg::OP_LOAD);
  assign accept_query = accept && (in_data.operation == pmd_pkg::OP_QUERY);

  // a query with an out-of-range row gets no features to compare: it compares nothing
  assign rows_ok = (32'(in_data.row_a) < MAX_ROWS) && (32'(in_data.row_b) < MAX_ROWS);
  assign feat_ok = (32'(in_data.row_a) < MAX_ROWS) &&
                   (32'(in_data.feature_index) < MAX_FEATURES);

  assign pipe_empty = !rd_pending && !term_valid;
  assign out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pmd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    issue      = 1'b0;
    out_load   = 1'b0;
    case (state)
      pmd_pkg::S_IDLE: begin
        if (accept_query) begin
          state_next = pmd_pkg::S_READ;
        end
      end
      pmd_pkg::S_READ: begin
        issue = (rd_cnt != q_limit);
        if (!issue && pipe_empty) begin
          state_next = pmd_pkg::S_FINISH;
        end
      end
      pmd_pkg::S_FINISH: begin
        // hold the finished sum until the output register can take it
        if (out_free) begin
          out_load   = 1'b1;
          state_next = pmd_pkg::S_IDLE;
        end
      end
      default: state_next = pmd_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Feature store: one write port for loads, two read ports for the query rows
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0]  waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [ADDR_W-1:0]  raddr_a;
  logic [ADDR_W-1:0]  raddr_b;
  logic [ENTRY_W-1:0] rdata_a;
  logic [ENTRY_W-1:0] rdata_b;

  // entry = {missing, value}
  assign waddr = ADDR_W'(in_data.row_a) * ADDR_W'(MAX_FEATURES) + ADDR_W'(in_data.feature_index);
  assign wdata = {in_data.value_missing, VALUE_BITS'(in_data.feature_value)};

  assign raddr_a = ADDR_W'(q_row_a) * ADDR_W'(MAX_FEATURES) + ADDR_W'(rd_cnt[FEAT_W-1:0]);
  assign raddr_b = ADDR_W'(q_row_b) * ADDR_W'(MAX_FEATURES) + ADDR_W'(rd_cnt[FEAT_W-1:0]);

  pmd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (accept_load && feat_ok),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // ---------------------------------------------------------------------------
  // Per-feature term, then saturating accumulate
  // ---------------------------------------------------------------------------
  logic                  miss_a, miss_b;
  logic [VALUE_BITS-1:0] val_a, val_b;
  logic [VALUE_BITS-1:0] term_next;
  logic [VALUE_BITS-1:0] term;
  logic [pmd_pkg::DIST_W-1:0] acc;
  logic [SUM_W-1:0]      sum;

  assign miss_a = rdata_a[VALUE_BITS];
  assign miss_b = rdata_b[VALUE_BITS];
  assign val_a  = rdata_a[VALUE_BITS-1:0];
  assign val_b  = rdata_b[VALUE_BITS-1:0];

  always_comb begin
    if (miss_a || miss_b) begin
      term_next = '0;
    end else if (q_mode == pmd_pkg::MODE_MISMATCH) begin
      term_next = VALUE_BITS'(val_a != val_b);
    end else if (val_a > val_b) begin
      term_next = val_a - val_b;
    end else begin
      term_next = val_b - val_a;
    end
  end

  assign sum = SUM_W'(acc) + SUM_W'(term);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
      term_valid <= 1'b0;
    end else begin
      rd_pending <= issue;
      term_valid <= rd_pending;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_query) begin
      q_row_a <= in_data.row_a;
      q_row_b <= in_data.row_b;
      q_limit <= rows_ok ? fc_limit : '0;
      q_mode  <= distance_mode;
      rd_cnt  <= '0;
      acc     <= '0;
    end else begin
      if (issue) begin
        rd_cnt <= rd_cnt + CNT_W'(1);
      end
      if (term_valid) begin
        acc <= (sum > SUM_W'(pmd_pkg::DIST_MAX)) ? pmd_pkg::DIST_MAX
                                                 : sum[pmd_pkg::DIST_W-1:0];
      end
    end
    if (rd_pending) begin
      term <= term_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.distance   <= acc;
      out_data.first_row  <= q_row_a;
      out_data.second_row <= q_row_b;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == pmd_pkg::S_READ) |-> (rd_cnt <= q_limit))
    else $error("read counter ran past the feature limit");

  a_finish_drained: assert property (@(posedge clk) disable iff (rst)
    (state == pmd_pkg::S_FINISH) |-> pipe_empty)
    else $error("query finished with reads still in flight");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == pmd_pkg::S_IDLE) |-> (pipe_empty && !issue))
    else $error("store read activity while idle");

  a_result_after_finish: assert property (@(posedge clk) disable iff (rst)
    (state == pmd_pkg::S_FINISH && out_free) |=> (out_valid && in_ready))
    else $error("finished query did not reach the output register");

endmodule

`default_nettype wire

// ===== src/pmd_ram.sv =====
`default_nettype none

module pmd_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== dv/pairwise_masked_distance_test.sv =====
`timescale 1ns / 1ps

module pairwise_masked_distance_test;
  import pmd_pkg::*;

  // Block sizes at the default parameters
  localparam int NUM_ROWS     = 256;
  localparam int NUM_FEATURES = 64;
  // Longest query: every feature read plus the pipeline overhead
  localparam int QUERY_CYCLES = NUM_FEATURES + 5;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_we    = 1'b0;
  logic              cfg_index = REG_DISTANCE_MODE;
  logic [CFG_W-1:0]  cfg_data  = '0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;

  pairwise_masked_distance uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Items waiting to be driven, and distances waiting to come back
  in_item_t  pending_items[$];
  out_item_t expected_results[$];

  // Local copy of the feature table and registers, updated on acceptance
  logic [VALUE_FIELD_W-1:0] level_store [NUM_ROWS][NUM_FEATURES];
  bit                       absent_store[NUM_ROWS][NUM_FEATURES];
  logic                     cur_mode  = MODE_MISMATCH;
  logic [CFG_W-1:0]         cur_count = FEATURE_COUNT_RESET;

  // Which slots the stimulus has written so far; queries only touch written slots
  bit loaded[NUM_ROWS][NUM_FEATURES];
  int ready_rows[$];

  int   items_queued   = 0;
  int   items_accepted = 0;
  int   mismatches     = 0;
  logic in_taken       = 1'b0;
  int   in_gap         = 0;
  int   out_gap        = 0;
  bit   idle_in_on     = 1'b0;
  bit   idle_out_on    = 1'b0;

  // Distance over the leading features present in both rows.
  // Count above the table width saturates; the sum is clipped to 22 bits.
  function automatic logic [DIST_W-1:0] masked_distance(input logic [ROW_FIELD_W-1:0] a,
                                                        input logic [ROW_FIELD_W-1:0] b);
    int     n;
    int     va;
    int     vb;
    longint acc;
    n   = (cur_count > NUM_FEATURES) ? NUM_FEATURES : int'(cur_count);
    acc = 0;
    for (int k = 0; k < n; k++) begin
      if (!absent_store[a][k] && !absent_store[b][k]) begin
        va = int'(level_store[a][k]);
        vb = int'(level_store[b][k]);
        if (cur_mode == MODE_MISMATCH) begin
          if (va != vb) acc += 1;
        end else begin
          acc += (va > vb) ? (va - vb) : (vb - va);
        end
      end
    end
    if (acc > longint'(DIST_MAX)) acc = longint'(DIST_MAX);
    return acc[DIST_W-1:0];
  endfunction

  // Small codes (0 to 3) so equal values turn up often, the extremes, and full-range values
  function automatic logic [VALUE_FIELD_W-1:0] pick_level();
    case ($urandom_range(0, 3))
      0: return VALUE_FIELD_W'($urandom_range(0, 3));
      1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return VALUE_FIELD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic bit row_ready(input int r, input int n);
    for (int k = 0; k < n; k++) begin
      if (!loaded[r][k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic queue_load(input int r, input int f, input logic [VALUE_FIELD_W-1:0] v,
                            input bit m);
    in_item_t it;
    it.operation     = OP_LOAD;
    it.row_a         = ROW_FIELD_W'(r);
    it.row_b         = ROW_FIELD_W'($urandom_range(0, 255));  // ignored on load
    it.feature_index = FEAT_FIELD_W'(f);
    it.feature_value = v;
    it.value_missing = m;
    loaded[r][f]     = 1'b1;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_query(input int a, input int b);
    in_item_t it;
    it.operation     = OP_QUERY;
    it.row_a         = ROW_FIELD_W'(a);
    it.row_b         = ROW_FIELD_W'(b);
    // load-only fields are don't-care here; keep them moving
    it.feature_index = FEAT_FIELD_W'($urandom_range(0, 63));
    it.feature_value = VALUE_FIELD_W'($urandom_range(0, 65535));
    it.value_missing = 1'($urandom_range(0, 1));
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_DISTANCE_MODE) cur_mode = val[0];
    else                          cur_count = val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Hold the sender back until every item is in and every distance is out,
  // then wait the extra cycles the caller asks for, so a trailing load can finish.
  task automatic settle(input int extra);
    while (items_accepted != items_queued || expected_results.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // Both register settings, then a mix of row fills with queries, queries
  // between rows already filled, self pairs and stray loads.
  task automatic run_phase(input logic mode, input int count, input int budget, input bit idling);
    int n;
    int r;
    int b;
    int sel;
    int start_items;
    bit known;
    settle(4);
    write_reg(REG_DISTANCE_MODE, mode);
    write_reg(REG_FEATURE_COUNT, CFG_W'(count));
    idle_in_on  = idling;
    idle_out_on = idling;
    @(posedge clk);
    n = (count > NUM_FEATURES) ? NUM_FEATURES : count;
    ready_rows.delete();
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (row_ready(i, n)) ready_rows.push_back(i);
    end
    start_items = items_queued;
    while (items_queued - start_items < budget) begin
      sel = $urandom_range(0, 99);
      if (ready_rows.size() < 2 || sel < 25) begin
        // fill a row over the compared features, then pair it with another
        r = $urandom_range(0, NUM_ROWS - 1);
        for (int k = 0; k < n; k++) begin
          if (!loaded[r][k] || $urandom_range(0, 1))
            queue_load(r, k, pick_level(), $urandom_range(0, 5) == 0);
        end
        known = 1'b0;
        foreach (ready_rows[i]) if (ready_rows[i] == r) known = 1'b1;
        if (!known) ready_rows.push_back(r);
        b = ready_rows[$urandom_range(0, ready_rows.size() - 1)];
        if ($urandom_range(0, 1)) queue_query(r, b);
        else                      queue_query(b, r);
      end else if (sel < 65) begin
        queue_query(ready_rows[$urandom_range(0, ready_rows.size() - 1)],
                    ready_rows[$urandom_range(0, ready_rows.size() - 1)]);
      end else if (sel < 75) begin
        r = ready_rows[$urandom_range(0, ready_rows.size() - 1)];
        queue_query(r, r);
      end else begin
        queue_load($urandom_range(0, NUM_ROWS - 1), $urandom_range(0, NUM_FEATURES - 1),
                   pick_level(), $urandom_range(0, 3) == 0);
      end
    end
  endtask

  // Sender: new item on the falling edge once the previous one has gone in
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   = 0;
    end else if (!in_valid || in_taken) begin
      if (in_gap == 0 && idle_in_on && $urandom_range(0, 5) == 0)
        in_gap = $urandom_range(1, 13);
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls in bursts while idling is enabled
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      out_gap   = 0;
    end else begin
      if (out_gap == 0 && idle_out_on && $urandom_range(0, 5) == 0)
        out_gap = $urandom_range(1, 13);
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: check the finished distance first, then account for the item
  // taken on this edge, since both can happen together.
  always @(posedge clk) begin : monitor
    out_item_t want;
    in_taken <= in_valid && in_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: distance %0d, rows %0d/%0d",
                 out_data.distance, out_data.first_row, out_data.second_row);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.distance !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, out_data.distance);
            mismatches++;
          end
          if (out_data.first_row !== want.first_row) begin
            $error("first_row: expected %0d, got %0d", want.first_row, out_data.first_row);
            mismatches++;
          end
          if (out_data.second_row !== want.second_row) begin
            $error("second_row: expected %0d, got %0d", want.second_row, out_data.second_row);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        items_accepted++;
        if (in_data.operation == OP_LOAD) begin
          level_store[in_data.row_a][in_data.feature_index]  = in_data.feature_value;
          absent_store[in_data.row_a][in_data.feature_index] = in_data.value_missing;
        end else begin
          want.distance   = masked_distance(in_data.row_a, in_data.row_b);
          want.first_row  = in_data.row_a;
          want.second_row = in_data.row_b;
          expected_results.push_back(want);
        end
      end
    end
  end

  // Stimulus
  initial begin
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Directed: three features, rows 0 and 255 at the value extremes, one
    // missing slot, a fully missing row and a self pair.
    write_reg(REG_FEATURE_COUNT, CFG_W'(3));
    @(posedge clk);
    queue_load(0, 0, 16'h0000, 1'b0);
    queue_load(0, 1, 16'hFFFF, 1'b0);
    queue_load(0, 2, 16'h0007, 1'b1);
    queue_load(255, 0, 16'hFFFF, 1'b0);
    queue_load(255, 1, 16'hFFFF, 1'b0);
    queue_load(255, 2, 16'h0000, 1'b0);
    queue_load(0, 63, 16'hFFFF, 1'b1);   // top slot, outside the compared range
    queue_query(0, 255);
    queue_query(255, 0);
    queue_query(0, 0);
    for (int k = 0; k < 3; k++) queue_load(170, k, pick_level(), 1'b1);
    queue_query(170, 0);                 // everything masked out
    settle(4);
    write_reg(REG_DISTANCE_MODE, MODE_ABSOLUTE);
    @(posedge clk);
    queue_query(0, 255);                 // largest single-feature difference
    queue_query(255, 255);
    queue_query(170, 255);

    // Random phases; count 0 compares nothing, 65 and 127 saturate at 64
    run_phase(MODE_MISMATCH, 4, 100, 1'b1);
    run_phase(MODE_ABSOLUTE, 1, 60, 1'b0);
    run_phase(MODE_ABSOLUTE, 127, 160, 1'b1);
    run_phase(MODE_MISMATCH, 64, 120, 1'b1);
    run_phase(MODE_ABSOLUTE, 0, 30, 1'b1);
    run_phase(MODE_MISMATCH, $urandom_range(1, 12), 100, 1'b1);
    run_phase(MODE_ABSOLUTE, $urandom_range(5, 20), 100, 1'b1);
    run_phase(MODE_MISMATCH, 65, 80, 1'b0);

    settle(QUERY_CYCLES + 5);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
